@@ rtl/core/accumulator_cpu_step_macros.svh @@
// Assertion macros for the accumulator step machine.
// Used by the top level only; no other dependencies.
`ifndef ACCUMULATOR_CPU_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_STEP_MACROS_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define ACS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that a condition holds whenever enabled.
`define ACS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/acs_pkg.sv @@
// Package for the accumulator step machine: widths, opcodes, helpers.
// No dependencies.
`default_nettype none
package acs_pkg;
  localparam int MemBytes = 2048;
  localparam int AddrW = $clog2(MemBytes);
  localparam int PcW = 11;
  localparam int WordW = 16;

  typedef enum logic [3:0] {
    OP_EOC = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_READ = 4'd3,
    OP_WRITE = 4'd4, OP_ADD = 4'd5, OP_SUB = 4'd6, OP_MUL = 4'd7,
    OP_DIV = 4'd8, OP_MOD = 4'd9, OP_NEG = 4'd10, OP_NOP = 4'd11,
    OP_JUMP = 4'd12, OP_JNEG = 4'd13, OP_JZERO = 4'd14, OP_HALT = 4'd15
  } opcode_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;

  // byte address from a 12-bit value, wrapped to the memory size
  // (memory size is a power of two, so the low address bits are the wrap)
  function automatic logic [AddrW-1:0] wrap_addr(input logic [PcW:0] a);
    return a[AddrW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/acs_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on acs_pkg.
`default_nettype none
module acs_divider import acs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  // magnitude of the dividend is at most 2^15, divisor is unsigned 16 bits
  logic [WordW-1:0] q_r, q_nxt;
  logic [WordW:0]   rem_r, rem_nxt;
  logic [WordW-1:0] dvs_r;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, neg_r, done_r;
  logic [WordW:0]   trial;
  logic [WordW:0]   shifted;

  always_comb begin
    shifted = {rem_r[WordW-1:0], q_r[WordW-1]};
    trial   = shifted - {1'b0, dvs_r};
    q_nxt   = {q_r[WordW-2:0], ~trial[WordW]};
    rem_nxt = trial[WordW] ? shifted : trial;
    cnt_nxt = cnt_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(WordW);
        neg_r  <= req.dividend[WordW-1];
        q_r    <= req.dividend[WordW-1] ? (WordW)'(-req.dividend) : req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.quot = neg_r ? (WordW)'(-q_r) : q_r;
    rsp.rem  = neg_r ? (WordW)'(-rem_r[WordW-1:0]) : rem_r[WordW-1:0];
  end
endmodule
`default_nettype wire

@@ rtl/core/accumulator_cpu_step.sv @@
// Top level: sequencer, byte memory with clearing pass, shared divider.
// Depends on acs_pkg, acs_divider and accumulator_cpu_step_macros.svh.
//
//  channel | ports                        | handshake
//  input   | in_req_type .. in_read_value | start & !busy
//  result  | out_*                        | out_strobe, one cycle, no stall
//
// A load writes two bytes; a step reads the instruction, pointer if indirect
// and operand, then executes; DIV/MOD wait on the one-bit-per-cycle divider
// and a halted step ends at once. After reset a clearing pass zeroes the
// memory with busy high. The receiver cannot stall.
`default_nettype none
`include "accumulator_cpu_step_macros.svh"
module accumulator_cpu_step import acs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [PcW-1:0]     in_load_address,
  input  wire logic [WordW-1:0]   in_load_word,
  input  wire logic [WordW-1:0]   in_read_value,
  output logic                    out_strobe,
  output logic [PcW-1:0]          out_pc_out,
  output logic signed [WordW-1:0] out_acc_out,
  output logic [WordW-1:0]        out_instr_out,
  output logic [3:0]              out_opcode_out,
  output logic [PcW-1:0]          out_operand_out,
  output logic                    out_write_valid,
  output logic [WordW-1:0]        out_write_value,
  output logic                    out_halted,
  output logic                    out_status
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR_HI, S_WR_LO, S_F_HI, S_F_LO, S_DECODE,
    S_I_HI, S_I_LO, S_E_HI, S_E_LO, S_EXEC, S_DIV, S_DONE
  } state_t;

  state_t state_r;
  logic [7:0]       mem [MemBytes];
  logic [7:0]       rd_data_r;
  logic [AddrW-1:0] clr_r;
  logic [WordW-1:0] acc_r, instr_r, wval_r, lword_r, rval_r, mword_r;
  logic [PcW-1:0]   pc_r, operand_r, laddr_r, ea_r;
  logic [3:0]       opcode_r;
  logic             halt_r, ind_r, wvalid_r, status_r, req_r;
  logic [7:0]       hi_r;
  // memory port
  logic             we;
  logic [AddrW-1:0] maddr;
  logic [7:0]       wdata;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic [WordW-1:0] prod;

  acs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // single-port byte memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wdata;
    rd_data_r <= mem[maddr];
  end

  // write data for STORE/READ
  logic [WordW-1:0] st_word;
  assign st_word = (opcode_r == OP_READ) ? rval_r : acc_r;
  assign prod = acc_r * mword_r;

  // memory address and write control per state
  always_comb begin
    we = 1'b0; maddr = '0; wdata = '0;
    unique case (state_r)
      S_CLEAR: begin we = 1'b1; maddr = clr_r; end
      S_IDLE: maddr = wrap_addr({1'b0, pc_r});
      S_WR_HI: begin
        we = 1'b1; maddr = wrap_addr({1'b0, laddr_r}); wdata = lword_r[15:8];
      end
      S_WR_LO: begin
        we = 1'b1; maddr = wrap_addr({1'b0, laddr_r} + 12'd1); wdata = lword_r[7:0];
      end
      S_F_HI: maddr = wrap_addr({1'b0, pc_r} + 12'd1);
      S_F_LO, S_DECODE: maddr = wrap_addr({1'b0, operand_r});
      S_I_HI: maddr = wrap_addr({1'b0, operand_r} + 12'd1);
      // effective address straight from the pointer bytes
      S_I_LO: maddr = wrap_addr({1'b0, hi_r[2:0], rd_data_r});
      S_E_HI: maddr = wrap_addr({1'b0, ea_r} + 12'd1);
      S_E_LO: maddr = wrap_addr({1'b0, ea_r});
      S_EXEC: begin
        we = (opcode_r == OP_STORE || opcode_r == OP_READ);
        maddr = wrap_addr({1'b0, ea_r}); wdata = st_word[15:8];
      end
      S_DIV: begin
        we = (opcode_r == OP_STORE || opcode_r == OP_READ);
        maddr = wrap_addr({1'b0, ea_r} + 12'd1); wdata = st_word[7:0];
      end
      default: maddr = '0;
    endcase
  end

  always_comb begin
    dreq.start    = (state_r == S_EXEC) &&
                    (opcode_r == OP_DIV || opcode_r == OP_MOD) && (mword_r != '0);
    dreq.dividend = acc_r;
    dreq.divisor  = mword_r;
  end

  assign busy = (state_r != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0;
      acc_r <= '0; pc_r <= '0; instr_r <= '0; opcode_r <= '0;
      operand_r <= '0; halt_r <= 1'b0; out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AddrW'(MemBytes - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req_r <= in_req_type; laddr_r <= in_load_address;
          lword_r <= in_load_word; rval_r <= in_read_value;
          wvalid_r <= 1'b0; wval_r <= '0; status_r <= 1'b0;
          if (!in_req_type) state_r <= S_WR_HI;
          else if (halt_r) state_r <= S_DONE;
          else state_r <= S_F_HI;
        end
        S_WR_HI: state_r <= S_WR_LO;
        S_WR_LO: state_r <= S_DONE;
        S_F_HI: begin hi_r <= rd_data_r; state_r <= S_F_LO; end
        S_F_LO: begin
          instr_r   <= {hi_r, rd_data_r};
          opcode_r  <= hi_r[7:4];
          ind_r     <= hi_r[3];
          operand_r <= {hi_r[2:0], rd_data_r};
          pc_r      <= pc_r + 11'd2;
          state_r   <= S_DECODE;
        end
        S_DECODE: begin
          ea_r <= operand_r;
          state_r <= ind_r ? S_I_HI : S_E_HI;
        end
        S_I_HI: begin hi_r <= rd_data_r; state_r <= S_I_LO; end
        S_I_LO: begin ea_r <= {hi_r[2:0], rd_data_r}; state_r <= S_E_HI; end
        S_E_HI: begin hi_r <= rd_data_r; state_r <= S_E_LO; end
        S_E_LO: begin mword_r <= {hi_r, rd_data_r}; state_r <= S_EXEC; end
        S_EXEC: begin
          state_r <= S_DONE;
          unique case (opcode_t'(opcode_r))
            OP_EOC, OP_HALT: halt_r <= 1'b1;
            OP_LOAD: acc_r <= mword_r;
            OP_STORE, OP_READ: state_r <= S_DIV;
            OP_WRITE: begin wvalid_r <= 1'b1; wval_r <= mword_r; end
            OP_ADD: acc_r <= acc_r + mword_r;
            OP_SUB: acc_r <= acc_r - mword_r;
            OP_MUL: acc_r <= prod;
            OP_DIV, OP_MOD: begin
              if (mword_r == '0) status_r <= 1'b1;
              else state_r <= S_DIV;
            end
            OP_NEG: acc_r <= (WordW)'(-acc_r);
            OP_NOP: ;
            OP_JUMP: pc_r <= operand_r;
            OP_JNEG: if (acc_r[15]) pc_r <= operand_r;
            OP_JZERO: if (acc_r == '0) pc_r <= operand_r;
            default: ;
          endcase
        end
        // second store byte, or wait for the divider
        S_DIV: begin
          if (opcode_r == OP_STORE || opcode_r == OP_READ) state_r <= S_DONE;
          else if (drsp.done) begin
            acc_r <= (opcode_r == OP_DIV) ? drsp.quot : drsp.rem;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin out_strobe <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_pc_out      = pc_r;
  assign out_acc_out     = acc_r;
  assign out_instr_out   = instr_r;
  assign out_opcode_out  = opcode_r;
  assign out_operand_out = operand_r;
  assign out_write_valid = wvalid_r;
  assign out_write_value = wval_r;
  assign out_halted      = halt_r;
  assign out_status      = status_r;

  `ACS_ASSERT_SAME(a_strobe_idle, out_strobe, !busy)
  `ACS_ASSERT_SAME(a_status_divop, out_strobe && out_status,
    req_r && (out_opcode_out == OP_DIV || out_opcode_out == OP_MOD))
  `ACS_ASSERT_SAME(a_wvalid_write, out_strobe && out_write_valid,
    req_r && out_opcode_out == OP_WRITE)
endmodule
`default_nettype wire

@@ tb/accumulator_cpu_step_test.sv @@
// Self-checking testbench for the accumulator step machine: directed and random
// program words and steps, checked against an in-bench machine model.
// Depends on acs_pkg and the accumulator_cpu_step RTL.
`default_nettype none
module accumulator_cpu_step_test;
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [10:0] pc;
    logic [15:0] acc;
    logic [15:0] instr;
    logic [3:0]  opcode;
    logic [10:0] operand;
    logic        wr_valid;
    logic [15:0] wr_value;
    logic        halted;
    logic        status;
  } machine_view_t;

  logic clk, rst_n, start, busy;
  logic in_req_type;
  logic [10:0] in_load_address;
  logic [15:0] in_load_word, in_read_value;
  logic out_strobe, out_write_valid, out_halted, out_status;
  logic [10:0] out_pc_out, out_operand_out;
  logic signed [15:0] out_acc_out;
  logic [15:0] out_instr_out, out_write_value;
  logic [3:0] out_opcode_out;

  accumulator_cpu_step u_dut (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_load_address, .in_load_word,
    .in_read_value, .out_strobe, .out_pc_out, .out_acc_out, .out_instr_out,
    .out_opcode_out, .out_operand_out, .out_write_valid, .out_write_value,
    .out_halted, .out_status
  );

  // machine model state
  logic [7:0]  mem_img [0:2047];
  logic [15:0] acc_m, ir_m;
  logic [10:0] pc_m, opnd_m;
  logic [3:0]  op_m;
  logic        halt_m;

  machine_view_t pending_views[$];
  int errors, n_loads, n_steps, n_words_out, div_zero_seen;
  int op_seen [16];
  bit no_idle;
  int idle_cycles;

  initial begin
    clk = 0;
  end
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic logic [15:0] model_read(logic [10:0] a);
    return {mem_img[a], mem_img[a + 11'd1]};
  endfunction

  function automatic void model_write(logic [10:0] a, logic [15:0] v);
    mem_img[a] = v[15:8];
    mem_img[a + 11'd1] = v[7:0];
  endfunction

  // advance the model by one word and return what the block should report
  function automatic machine_view_t predict_machine(logic req, logic [10:0] la,
                                                    logic [15:0] lw, logic [15:0] rv);
    machine_view_t v;
    logic [15:0] ea, opw;
    int dividend, divisor, r;
    v = '0;
    if (!req) begin
      model_write(la, lw);
    end else if (!halt_m) begin
      ir_m = model_read(pc_m);
      op_m = ir_m[15:12];
      opnd_m = ir_m[10:0];
      pc_m = pc_m + 11'd2;
      ea = ir_m[11] ? model_read(opnd_m) : {5'd0, opnd_m};
      opw = model_read(ea[10:0]);
      op_seen[op_m]++;
      case (opcode_t'(op_m))
        OP_EOC, OP_HALT: halt_m = 1'b1;
        OP_LOAD:  acc_m = opw;
        OP_STORE: model_write(ea[10:0], acc_m);
        OP_READ:  model_write(ea[10:0], rv);
        OP_WRITE: begin
          v.wr_valid = 1'b1;
          v.wr_value = opw;
        end
        OP_ADD: acc_m = acc_m + opw;
        OP_SUB: acc_m = acc_m - opw;
        OP_MUL: acc_m = acc_m * opw;
        OP_DIV, OP_MOD: begin
          if (opw == 16'd0) begin
            v.status = 1'b1;
          end else begin
            dividend = $signed(acc_m);
            divisor = int'(opw);
            r = (opcode_t'(op_m) == OP_DIV) ? dividend / divisor : dividend % divisor;
            acc_m = r[15:0];
          end
        end
        OP_NEG:   acc_m = -acc_m;
        OP_JUMP:  pc_m = opnd_m;
        OP_JNEG:  if (acc_m[15]) pc_m = opnd_m;
        OP_JZERO: if (acc_m == 16'd0) pc_m = opnd_m;
        default: ;
      endcase
    end
    v.pc = pc_m;
    v.acc = acc_m;
    v.instr = ir_m;
    v.opcode = op_m;
    v.operand = opnd_m;
    v.halted = halt_m;
    return v;
  endfunction

  // drive one word on the input channel and record its expected result
  task automatic send_word(logic req, logic [10:0] la, logic [15:0] lw, logic [15:0] rv);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < 22) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_req_type = req;
    in_load_address = la;
    in_load_word = lw;
    in_read_value = rv;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_views.push_back(predict_machine(req, la, lw, rv));
    if (req) n_steps++;
    else n_loads++;
    // block is busy right after the accept, so drop start before it frees up
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic poke(logic [10:0] a, logic [15:0] w);
    send_word(1'b0, a, w, 16'($urandom));
  endtask

  // place an instruction at the current pc, then step it
  task automatic exec(opcode_t op, logic ind, logic [10:0] opnd, logic [15:0] rv);
    poke(pc_m, {op, ind, opnd});
    send_word(1'b1, 11'($urandom), 16'($urandom), rv);
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%04h, got 0x%04h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    machine_view_t e;
    if (rst_n && out_strobe) begin
      if (pending_views.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        e = pending_views.pop_front();
        n_words_out++;
        if (e.status) div_zero_seen++;
        check_field("pc_out", 16'(e.pc), 16'(out_pc_out));
        check_field("acc_out", e.acc, out_acc_out);
        check_field("instr_out", e.instr, out_instr_out);
        check_field("opcode_out", 16'(e.opcode), 16'(out_opcode_out));
        check_field("operand_out", 16'(e.operand), 16'(out_operand_out));
        check_field("write_valid", 16'(e.wr_valid), 16'(out_write_valid));
        check_field("write_value", e.wr_value, out_write_value);
        check_field("halted", 16'(e.halted), 16'(out_halted));
        check_field("status", 16'(e.status), 16'(out_status));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // arithmetic and data edge cases, both address modes, wrap at top of memory
  task automatic test_directed();
    poke(11'd1000, 16'h7FFF);
    poke(11'd1002, 16'hFFFF);
    poke(11'd1004, 16'h0000);
    poke(11'd1006, 16'd2);
    poke(11'd1008, 16'd1002);
    exec(OP_LOAD, 1'b0, 11'd1000, 16'h0);
    exec(OP_ADD, 1'b0, 11'd1000, 16'h0);
    exec(OP_SUB, 1'b1, 11'd1008, 16'h0);
    exec(OP_MUL, 1'b0, 11'd1002, 16'h0);
    exec(OP_DIV, 1'b0, 11'd1004, 16'h0);
    exec(OP_MOD, 1'b0, 11'd1004, 16'h0);
    exec(OP_READ, 1'b0, 11'd1010, 16'hFFF9);
    exec(OP_LOAD, 1'b0, 11'd1010, 16'h0);
    exec(OP_DIV, 1'b0, 11'd1006, 16'h0);
    exec(OP_READ, 1'b0, 11'd1012, 16'h8000);
    exec(OP_LOAD, 1'b0, 11'd1012, 16'h0);
    exec(OP_NEG, 1'b0, 11'd0, 16'h0);
    exec(OP_MOD, 1'b0, 11'd1002, 16'h0);
    exec(OP_JNEG, 1'b0, 11'd2047, 16'h0);
    exec(OP_STORE, 1'b1, 11'd1008, 16'h0);
    exec(OP_WRITE, 1'b0, 11'd2047, 16'h0);
    exec(OP_JZERO, 1'b0, 11'd0, 16'h0);
    exec(OP_NOP, 1'b0, 11'd2047, 16'h0);
    exec(OP_JUMP, 1'b0, 11'd1200, 16'h0);
  endtask

  // mostly well-formed instruction sequences, with stray program words as noise
  task automatic test_random_programs(int count);
    opcode_t op;
    logic [10:0] opnd;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      if ($urandom_range(9) == 0) begin
        poke(11'($urandom), 16'($urandom));
      end else begin
        op = opcode_t'($urandom_range(int'(OP_JZERO), int'(OP_LOAD)));
        opnd = ($urandom_range(7) == 0) ? 11'($urandom_range(1) * 2047) : 11'($urandom);
        if ($urandom_range(1)) poke(opnd, 16'($urandom_range(3) == 0 ? 0 : $urandom));
        exec(op, 1'($urandom), opnd, 16'($urandom));
        i++;
      end
    end
    no_idle = 1'b0;
  endtask

  // hold the sender until every expected result has come back
  task automatic test_drain_pause();
    while (pending_views.size() != 0) @(posedge clk);
    repeat ($urandom_range(40, 5)) @(posedge clk);
  endtask

  // end of program, then steps and program writes while halted
  task automatic test_halt();
    exec($urandom_range(1) ? OP_HALT : OP_EOC, 1'($urandom), 11'($urandom), 16'($urandom));
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) poke(11'($urandom), 16'($urandom));
      else send_word(1'b1, 11'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int waited;
    for (int a = 0; a < 2048; a++) mem_img[a] = 8'h00;
    acc_m = '0; ir_m = '0; pc_m = '0; opnd_m = '0; op_m = '0; halt_m = 1'b0;
    errors = 0; n_loads = 0; n_steps = 0; n_words_out = 0; div_zero_seen = 0;
    no_idle = 1'b0;
    foreach (op_seen[k]) op_seen[k] = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = 1'b0;
    in_load_address = '0;
    in_load_word = '0;
    in_read_value = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_programs(640);
    test_drain_pause();
    test_random_programs(600);
    test_halt();

    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (pending_views.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_views.size() != 0) begin
      $error("%0d expected results never arrived", pending_views.size());
      errors++;
    end

    $display("Covered %0d program writes and %0d steps, %0d results checked,",
             n_loads, n_steps, n_words_out);
    $display("  %0d zero-divisor steps, halt reached: %0d", div_zero_seen, halt_m);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/acs_pkg.sv
rtl/core/acs_divider.sv
rtl/core/accumulator_cpu_step.sv
tb/accumulator_cpu_step_test.sv
